@@ hdl/ksem_pkg.sv @@
// Package for the keyed semaphore table: sizes, opcodes, status codes and helpers.
// No dependencies; ksem_req_if, ksem_rsp_if and keyed_semaphore_table import it.
package ksem_pkg;

  localparam int NUM_SEMAS = 16;
  localparam int NUM_SLOTS = 64;
  localparam int SEMA_W    = $clog2(NUM_SEMAS);
  localparam int SLOT_W    = 6;
  localparam int LEN_W     = $clog2(NUM_SLOTS + 1);
  localparam int SCAN_W    = SEMA_W + 1;
  localparam int POS_W     = $clog2(NUM_SLOTS);
  localparam int WQ_AW     = SEMA_W + POS_W;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = 32;
  localparam int KC_W      = KEY_W + CNT_W;

  localparam logic [2:0] OP_OPEN    = 3'd0;
  localparam logic [2:0] OP_DOWN    = 3'd1;
  localparam logic [2:0] OP_UP      = 3'd2;
  localparam logic [2:0] OP_DESTROY = 3'd3;
  localparam logic [2:0] OP_CLEANUP = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOINIT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef logic [NUM_SLOTS-1:0] ref_mask_t;

  function automatic ref_mask_t slot_bit(input logic [SLOT_W-1:0] slot);
    ref_mask_t m;
    m = '0;
    if (int'(slot) < NUM_SLOTS) begin
      m[slot[POS_W-1:0]] = 1'b1;
    end
    return m;
  endfunction

endpackage

@@ hdl/ksem_req_if.sv @@
// Request channel of the keyed semaphore table: valid/ready plus one operation.
// Depends on ksem_pkg.
interface ksem_req_if import ksem_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               opcode;
  logic [SEMA_W-1:0]        sema_id;
  logic signed [KEY_W-1:0]  key;
  logic signed [CNT_W-1:0]  init_value;
  logic [SLOT_W-1:0]        caller_slot;

  modport source (output valid, opcode, sema_id, key, init_value, caller_slot, input ready);
  modport sink   (input valid, opcode, sema_id, key, init_value, caller_slot, output ready);
endinterface

@@ hdl/ksem_rsp_if.sv @@
// Response channel of the keyed semaphore table: valid/ready plus one result.
// Depends on ksem_pkg.
interface ksem_rsp_if import ksem_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [SEMA_W-1:0]     result_id;
  logic                  caller_blocks;
  logic                  woken_valid;
  logic [SLOT_W-1:0]     woken_slot;
  logic [NUM_SLOTS-1:0]  woken_mask;

  modport source (output valid, status, result_id, caller_blocks, woken_valid, woken_slot,
                  woken_mask, input ready);
  modport sink   (input valid, status, result_id, caller_blocks, woken_valid, woken_slot,
                  woken_mask, output ready);
endinterface

@@ hdl/ksem_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ksem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/keyed_semaphore_table.sv @@
// Keyed semaphore table. One operation at a time; the result sits in an output register.
// Open reads one key per cycle over 16 entries; destroy, and cleanup for each entry it
// releases, walk that entry's waiter queue when it is not empty.
// A new request is taken as soon as the sequencer is idle, even while a result waits.
// Reset clears reference masks, queue heads and lengths at once; no clearing pass.
// Uses ksem_pkg, ksem_req_if, ksem_rsp_if and ksem_ram.
module keyed_semaphore_table import ksem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ksem_req_if.sink  req_i,
  ksem_rsp_if.source rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPEN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_CLN  = 3'd4;
  localparam logic [2:0] S_DRN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [2:0]         op_q, op_d;
  logic [SEMA_W-1:0]  sid_q, sid_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [CNT_W-1:0]   init_q, init_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SCAN_W-1:0]  scan_q, scan_d;
  logic               cmp_v_q, cmp_v_d;
  logic [SEMA_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [SEMA_W-1:0]  ent_q, ent_d;
  logic [LEN_W-1:0]   iss_q, iss_d;
  logic               rdv_q, rdv_d;

  ref_mask_t          ref_q [NUM_SEMAS];
  ref_mask_t          ref_d [NUM_SEMAS];
  logic [POS_W-1:0]   head_q [NUM_SEMAS];
  logic [POS_W-1:0]   head_d [NUM_SEMAS];
  logic [LEN_W-1:0]   len_q [NUM_SEMAS];
  logic [LEN_W-1:0]   len_d [NUM_SEMAS];

  logic [1:0]         res_st_q, res_st_d;
  logic [SEMA_W-1:0]  res_rid_q, res_rid_d;
  logic               res_blk_q, res_blk_d;
  logic               res_wv_q, res_wv_d;
  logic [SLOT_W-1:0]  res_ws_q, res_ws_d;
  ref_mask_t          res_mask_q, res_mask_d;

  logic               out_v_q, out_v_d;
  logic [1:0]         out_st_q, out_st_d;
  logic [SEMA_W-1:0]  out_rid_q, out_rid_d;
  logic               out_blk_q, out_blk_d;
  logic               out_wv_q, out_wv_d;
  logic [SLOT_W-1:0]  out_ws_q, out_ws_d;
  ref_mask_t          out_mask_q, out_mask_d;

  logic [NUM_SEMAS-1:0] ref_nz;
  logic                 free_any;
  logic [SEMA_W-1:0]    free_idx;

  logic               kc_we;
  logic [SEMA_W-1:0]  kc_waddr, kc_raddr;
  logic [KC_W-1:0]    kc_wdata, kc_rdata;
  logic               wq_we;
  logic [WQ_AW-1:0]   wq_waddr, wq_raddr;
  logic [SLOT_W-1:0]  wq_rdata;

  logic               in_fire;
  ref_mask_t          slot_b;
  ref_mask_t          cln_left;
  logic [CNT_W-1:0]   new_cnt;
  logic [POS_W-1:0]   tail_pos;

  ksem_ram #(.WIDTH(KC_W), .DEPTH(NUM_SEMAS)) u_kc_ram (
    .clk_i   (clk_i),
    .we_i    (kc_we),
    .waddr_i (kc_waddr),
    .wdata_i (kc_wdata),
    .raddr_i (kc_raddr),
    .rdata_o (kc_rdata)
  );

  ksem_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SEMAS * NUM_SLOTS)) u_wq_ram (
    .clk_i   (clk_i),
    .we_i    (wq_we),
    .waddr_i (wq_waddr),
    .wdata_i (slot_q),
    .raddr_i (wq_raddr),
    .rdata_o (wq_rdata)
  );

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NUM_SEMAS; i++) begin
      ref_nz[i] = |ref_q[i];
    end
    for (int i = NUM_SEMAS - 1; i >= 0; i--) begin
      if (!ref_nz[i]) begin
        free_any = 1'b1;
        free_idx = SEMA_W'(i);
      end
    end
  end

  assign in_fire  = req_i.valid && req_i.ready;
  assign slot_b   = slot_bit(slot_q);
  assign cln_left = ref_q[scan_q[SEMA_W-1:0]] & ~slot_b;
  assign tail_pos = head_q[sid_q] + len_q[sid_q][POS_W-1:0];

  assign kc_raddr = (state_q == S_OPEN) ? scan_q[SEMA_W-1:0] : sid_q;
  assign wq_raddr = (state_q == S_DRN) ? {ent_q, head_q[ent_q] + iss_q[POS_W-1:0]}
                                       : {sid_q, head_q[sid_q]};

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    sid_d     = sid_q;
    key_d     = key_q;
    init_d    = init_q;
    slot_d    = slot_q;
    scan_d    = scan_q;
    cmp_v_d   = 1'b0;
    cmp_idx_d = cmp_idx_q;
    ent_d     = ent_q;
    iss_d     = iss_q;
    rdv_d     = 1'b0;
    ref_d     = ref_q;
    head_d    = head_q;
    len_d     = len_q;
    res_st_d  = res_st_q;
    res_rid_d = res_rid_q;
    res_blk_d = res_blk_q;
    res_wv_d  = res_wv_q;
    res_ws_d  = res_ws_q;
    res_mask_d = res_mask_q;
    out_v_d   = out_v_q && !rsp_o.ready;
    out_st_d  = out_st_q;
    out_rid_d = out_rid_q;
    out_blk_d = out_blk_q;
    out_wv_d  = out_wv_q;
    out_ws_d  = out_ws_q;
    out_mask_d = out_mask_q;
    kc_we     = 1'b0;
    kc_waddr  = sid_q;
    kc_wdata  = '0;
    wq_we     = 1'b0;
    wq_waddr  = {sid_q, tail_pos};
    new_cnt   = kc_rdata[KC_W-1:KEY_W];

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d       = req_i.opcode;
          sid_d      = req_i.sema_id;
          key_d      = req_i.key;
          init_d     = req_i.init_value;
          slot_d     = req_i.caller_slot;
          scan_d     = '0;
          res_st_d   = ST_OK;
          res_rid_d  = '0;
          res_blk_d  = 1'b0;
          res_wv_d   = 1'b0;
          res_ws_d   = '0;
          res_mask_d = '0;
          case (req_i.opcode)
            OP_OPEN:    state_d = S_OPEN;
            OP_CLEANUP: state_d = S_CLN;
            OP_DOWN, OP_UP, OP_DESTROY: begin
              if (int'(req_i.sema_id) >= NUM_SEMAS) begin
                res_st_d = ST_RANGE;
                state_d  = S_DONE;
              end else if (!ref_nz[req_i.sema_id]) begin
                res_st_d = ST_NOINIT;
                state_d  = S_DONE;
              end else if (req_i.opcode == OP_DESTROY) begin
                ent_d   = req_i.sema_id;
                iss_d   = '0;
                state_d = S_DRN;
              end else begin
                state_d = S_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_OPEN: begin
        // issue one key read per cycle, compare the entry read the cycle before
        if (int'(scan_q) < NUM_SEMAS) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_q[SEMA_W-1:0];
          scan_d    = scan_q + 1'b1;
        end
        if (cmp_v_q && ref_nz[cmp_idx_q] && kc_rdata[KEY_W-1:0] == key_q) begin
          ref_d[cmp_idx_q] = ref_q[cmp_idx_q] | slot_b;
          res_rid_d = cmp_idx_q;
          cmp_v_d   = 1'b0;
          state_d   = S_DONE;
        end else if (!cmp_v_q && int'(scan_q) >= NUM_SEMAS) begin
          if (free_any) begin
            kc_we     = 1'b1;
            kc_waddr  = free_idx;
            kc_wdata  = {init_q, key_q};
            ref_d[free_idx]  = ref_mask_t'(1) | slot_b;
            head_d[free_idx] = '0;
            len_d[free_idx]  = '0;
            res_rid_d = free_idx;
          end else begin
            res_st_d = ST_FULL;
          end
          state_d = S_DONE;
        end
      end

      S_RD: state_d = S_MOD;

      S_MOD: begin
        kc_we = 1'b1;
        if (op_q == OP_DOWN) begin
          new_cnt = kc_rdata[KC_W-1:KEY_W] - 1'b1;
          if (new_cnt[CNT_W-1]) begin
            res_blk_d = 1'b1;
            if (int'(len_q[sid_q]) < NUM_SLOTS) begin
              wq_we        = 1'b1;
              len_d[sid_q] = len_q[sid_q] + 1'b1;
            end
          end
        end else begin
          new_cnt = kc_rdata[KC_W-1:KEY_W] + 1'b1;
          if ((new_cnt[CNT_W-1] || new_cnt == '0) && len_q[sid_q] != '0) begin
            res_wv_d      = 1'b1;
            res_ws_d      = wq_rdata;
            head_d[sid_q] = head_q[sid_q] + 1'b1;
            len_d[sid_q]  = len_q[sid_q] - 1'b1;
          end
        end
        kc_wdata = {new_cnt, kc_rdata[KEY_W-1:0]};
        state_d  = S_DONE;
      end

      S_CLN: begin
        if (int'(scan_q) >= NUM_SEMAS) begin
          state_d = S_DONE;
        end else begin
          scan_d = scan_q + 1'b1;
          if ((ref_q[scan_q[SEMA_W-1:0]] & slot_b) != '0) begin
            ref_d[scan_q[SEMA_W-1:0]] = cln_left;
            if (cln_left == '0) begin
              ent_d   = scan_q[SEMA_W-1:0];
              iss_d   = '0;
              state_d = S_DRN;
            end
          end
        end
      end

      S_DRN: begin
        // walk the waiter queue, one read per cycle
        if (iss_q < len_q[ent_q]) begin
          iss_d = iss_q + 1'b1;
          rdv_d = 1'b1;
        end
        if (rdv_q) begin
          res_mask_d = res_mask_q | slot_bit(wq_rdata);
        end
        if (iss_q == len_q[ent_q] && !rdv_q) begin
          head_d[ent_q] = '0;
          len_d[ent_q]  = '0;
          if (op_q == OP_DESTROY) begin
            ref_d[ent_q] = '0;
            state_d      = S_DONE;
          end else begin
            state_d = S_CLN;
          end
        end
      end

      S_DONE: begin
        if (!out_v_q || rsp_o.ready) begin
          out_v_d    = 1'b1;
          out_st_d   = res_st_q;
          out_rid_d  = res_rid_q;
          out_blk_d  = res_blk_q;
          out_wv_d   = res_wv_q;
          out_ws_d   = res_ws_q;
          out_mask_d = res_mask_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      cmp_v_q <= 1'b0;
      iss_q   <= '0;
      rdv_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < NUM_SEMAS; i++) begin
        ref_q[i]  <= '0;
        head_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      cmp_v_q <= cmp_v_d;
      iss_q   <= iss_d;
      rdv_q   <= rdv_d;
      out_v_q <= out_v_d;
      ref_q   <= ref_d;
      head_q  <= head_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sid_q      <= sid_d;
    key_q      <= key_d;
    init_q     <= init_d;
    slot_q     <= slot_d;
    cmp_idx_q  <= cmp_idx_d;
    ent_q      <= ent_d;
    res_st_q   <= res_st_d;
    res_rid_q  <= res_rid_d;
    res_blk_q  <= res_blk_d;
    res_wv_q   <= res_wv_d;
    res_ws_q   <= res_ws_d;
    res_mask_q <= res_mask_d;
    out_st_q   <= out_st_d;
    out_rid_q  <= out_rid_d;
    out_blk_q  <= out_blk_d;
    out_wv_q   <= out_wv_d;
    out_ws_q   <= out_ws_d;
    out_mask_q <= out_mask_d;
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_v_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.result_id     = out_rid_q;
  assign rsp_o.caller_blocks = out_blk_q;
  assign rsp_o.woken_valid   = out_wv_q;
  assign rsp_o.woken_slot    = out_ws_q;
  assign rsp_o.woken_mask    = out_mask_q;

  a_wake_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_wv_q) |-> (out_mask_q == '0))
    else $error("up wake and release mask reported together");

  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRN) |-> (iss_q <= len_q[ent_q]))
    else $error("queue drain ran past the queue length");

  a_open_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q == OP_OPEN && res_st_q == ST_OK) |-> ref_nz[res_rid_q])
    else $error("open finished on an unreferenced entry");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |=> (int'(len_q[sid_q]) <= NUM_SLOTS))
    else $error("waiter queue grew past its capacity");

endmodule
